[hw/rtl/gapath_pkg.sv]
// shared constants for the grid path search block
`timescale 1ns / 1ps
package gapath_pkg;

    localparam int GRID_SIZE_DEF = 32;

    // field widths of the stream items
    localparam int COORD_IN_W  = 5;
    localparam int LEN_W       = 10;
    localparam int S_DATA_W    = 32;
    localparam int M_DATA_W    = 24;
    localparam int LEN_MAX     = 1023;

    // request kinds carried in tuser
    localparam logic REQ_CELL   = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // per cell search status
    localparam logic [1:0] ST_NEW    = 2'd0;
    localparam logic [1:0] ST_OPEN   = 2'd1;
    localparam logic [1:0] ST_CLOSED = 2'd2;

    // move that reached a cell
    localparam logic [1:0] DIR_XM = 2'd0;
    localparam logic [1:0] DIR_XP = 2'd1;
    localparam logic [1:0] DIR_YP = 2'd2;
    localparam logic [1:0] DIR_YM = 2'd3;

endpackage

[hw/rtl/gapath_ram.sv]
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module gapath_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/grid_astar_path_search.sv]
// top level of the grid a-star path search
//
//  channel | dir | tdata / tuser                                   | per transfer
//  s_      | in  | tuser: req_type; tdata: cell, blocked, start, goal | cell write or search
//  m_      | out | tdata: found, next_x, next_y, path_length       | one per search
//
// a cell write within the grid goes to the wall memory from idle. a search with distinct,
// in-range start and goal first sweeps all 2^(2*clog2(GRID_SIZE)) entries of the status
// memory (one entry per cycle), then per expansion scans the open list, shifts the tail
// down and checks four neighbours (a read state and an evaluate state each, only the read
// state for a neighbour off the grid).
// after reset the wall and status memories are swept the same way; s_tready stays low.
// a finished result sits in the output register while cell writes continue.
`timescale 1ns / 1ps
module grid_astar_path_search
    import gapath_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // cell_x[4:0] cell_y[9:5] blocked[10] start_x[15:11] start_y[20:16]
    // goal_x[25:21] goal_y[30:26]
    input  logic [S_DATA_W-1:0] s_tdata,
    // req_type
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // found[0] next_x[5:1] next_y[10:6] path_length[20:11]
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int COORD_W  = $clog2(GRID_SIZE);
    localparam int ADDR_W   = 2 * COORD_W;
    localparam int ADDR_D   = 1 << ADDR_W;
    localparam int CELLS    = GRID_SIZE * GRID_SIZE;
    localparam int OADDR_W  = $clog2(CELLS);
    localparam int IDX_W    = $clog2(CELLS + 1);
    localparam int COST_W   = $clog2(CELLS) + 1;
    localparam int F_W      = COST_W + 2;

    // controller states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_INIT  = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_SHIFT = 4'd4;
    localparam logic [3:0] S_CLOSE = 4'd5;
    localparam logic [3:0] S_NBRD  = 4'd6;
    localparam logic [3:0] S_NBEV  = 4'd7;
    localparam logic [3:0] S_TRRD  = 4'd8;
    localparam logic [3:0] S_TREV  = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    // input fields
    logic [COORD_IN_W-1:0] in_cx, in_cy, in_sx, in_sy, in_gx, in_gy;
    logic                  in_blk;
    assign in_cx  = s_tdata[4:0];
    assign in_cy  = s_tdata[9:5];
    assign in_blk = s_tdata[10];
    assign in_sx  = s_tdata[15:11];
    assign in_sy  = s_tdata[20:16];
    assign in_gx  = s_tdata[25:21];
    assign in_gy  = s_tdata[30:26];

    // registers
    logic [3:0]            state_reg, state_next;
    logic                  boot_reg, boot_next;
    logic [ADDR_W-1:0]     clr_reg, clr_next;
    logic [ADDR_W-1:0]     start_reg, start_next;
    logic [ADDR_W-1:0]     goal_reg, goal_next;
    logic [IDX_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]      sc_issue_reg, sc_issue_next;
    logic                  sc_v1_reg, sc_v1_next;
    logic [IDX_W-1:0]      sc_i1_reg, sc_i1_next;
    logic                  sc_v2_reg, sc_v2_next;
    logic [IDX_W-1:0]      sc_i2_reg, sc_i2_next;
    logic [ADDR_W-1:0]     sc_c2_reg, sc_c2_next;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    logic [ADDR_W-1:0]     best_cell_reg, best_cell_next;
    logic [COST_W-1:0]     best_cost_reg, best_cost_next;
    logic [F_W-1:0]        best_f_reg, best_f_next;
    logic [IDX_W-1:0]      sh_rd_reg, sh_rd_next;
    logic                  sh_v_reg, sh_v_next;
    logic [OADDR_W-1:0]    sh_w_reg, sh_w_next;
    logic [1:0]            nb_d_reg, nb_d_next;
    logic [ADDR_W-1:0]     tr_c_reg, tr_c_next;
    logic [ADDR_W-1:0]     tr_step_reg, tr_step_next;
    logic [IDX_W-1:0]      tr_guard_reg, tr_guard_next;
    logic                  res_found_reg, res_found_next;
    logic [COORD_IN_W-1:0] res_x_reg, res_x_next;
    logic [COORD_IN_W-1:0] res_y_reg, res_y_next;
    logic [LEN_W-1:0]      res_len_reg, res_len_next;
    logic                  m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]   m_data_reg, m_data_next;

    // memory ports
    logic                  wall_we, wall_wdata, wall_rdata;
    logic [ADDR_W-1:0]     wall_waddr;
    logic                  st_we, cost_we, par_we;
    logic [ADDR_W-1:0]     cell_waddr, cell_raddr;
    logic [1:0]            st_wdata, st_rdata;
    logic [COST_W-1:0]     cost_wdata, cost_rdata;
    logic [1:0]            par_wdata, par_rdata;
    logic                  open_we;
    logic [OADDR_W-1:0]    open_waddr, open_raddr;
    logic [ADDR_W-1:0]     open_wdata, open_rdata;

    gapath_ram #(.WIDTH(1), .DEPTH(ADDR_D)) u_wall (
        .aclk(aclk), .we(wall_we), .waddr(wall_waddr), .wdata(wall_wdata),
        .raddr(cell_raddr), .rdata(wall_rdata));
    gapath_ram #(.WIDTH(2), .DEPTH(ADDR_D)) u_status (
        .aclk(aclk), .we(st_we), .waddr(cell_waddr), .wdata(st_wdata),
        .raddr(cell_raddr), .rdata(st_rdata));
    gapath_ram #(.WIDTH(COST_W), .DEPTH(ADDR_D)) u_cost (
        .aclk(aclk), .we(cost_we), .waddr(cell_waddr), .wdata(cost_wdata),
        .raddr(cell_raddr), .rdata(cost_rdata));
    gapath_ram #(.WIDTH(2), .DEPTH(ADDR_D)) u_parent (
        .aclk(aclk), .we(par_we), .waddr(cell_waddr), .wdata(par_wdata),
        .raddr(cell_raddr), .rdata(par_rdata));
    gapath_ram #(.WIDTH(ADDR_W), .DEPTH(CELLS)) u_open (
        .aclk(aclk), .we(open_we), .waddr(open_waddr), .wdata(open_wdata),
        .raddr(open_raddr), .rdata(open_rdata));

    // cell coordinate helpers
    logic [COORD_W-1:0] cur_x, cur_y, gl_x, gl_y, c2_x, c2_y, tr_x, tr_y;
    assign cur_x = best_cell_reg[COORD_W-1:0];
    assign cur_y = best_cell_reg[ADDR_W-1:COORD_W];
    assign gl_x  = goal_reg[COORD_W-1:0];
    assign gl_y  = goal_reg[ADDR_W-1:COORD_W];
    assign c2_x  = sc_c2_reg[COORD_W-1:0];
    assign c2_y  = sc_c2_reg[ADDR_W-1:COORD_W];
    assign tr_x  = tr_c_reg[COORD_W-1:0];
    assign tr_y  = tr_c_reg[ADDR_W-1:COORD_W];

    // f of the entry leaving the scan pipeline: cost plus manhattan distance to goal
    logic [COORD_W-1:0] h_dx, h_dy;
    logic [F_W-1:0]     sc_f;
    assign h_dx = (c2_x >= gl_x) ? (c2_x - gl_x) : (gl_x - c2_x);
    assign h_dy = (c2_y >= gl_y) ? (c2_y - gl_y) : (gl_y - c2_y);
    assign sc_f = F_W'(cost_rdata) + F_W'(h_dx) + F_W'(h_dy);

    // neighbour of the expanded cell
    logic               nb_ok;
    logic [COORD_W-1:0] nb_x, nb_y;
    always_comb begin
        nb_x  = cur_x;
        nb_y  = cur_y;
        nb_ok = 1'b0;
        unique case (nb_d_reg)
            DIR_XM: begin
                nb_ok = (cur_x != '0);
                nb_x  = cur_x - 1'b1;
            end
            DIR_XP: begin
                nb_ok = (32'(cur_x) < GRID_SIZE - 1);
                nb_x  = cur_x + 1'b1;
            end
            DIR_YP: begin
                nb_ok = (32'(cur_y) < GRID_SIZE - 1);
                nb_y  = cur_y + 1'b1;
            end
            DIR_YM: begin
                nb_ok = (cur_y != '0);
                nb_y  = cur_y - 1'b1;
            end
            default: nb_ok = 1'b0;
        endcase
    end

    // predecessor on the traced path, undoing the stored move
    logic               pr_ok;
    logic [COORD_W-1:0] pr_x, pr_y;
    always_comb begin
        pr_x  = tr_x;
        pr_y  = tr_y;
        pr_ok = 1'b0;
        unique case (par_rdata)
            DIR_XM: begin
                pr_ok = (32'(tr_x) < GRID_SIZE - 1);
                pr_x  = tr_x + 1'b1;
            end
            DIR_XP: begin
                pr_ok = (tr_x != '0);
                pr_x  = tr_x - 1'b1;
            end
            DIR_YP: begin
                pr_ok = (tr_y != '0);
                pr_y  = tr_y - 1'b1;
            end
            DIR_YM: begin
                pr_ok = (32'(tr_y) < GRID_SIZE - 1);
                pr_y  = tr_y + 1'b1;
            end
            default: pr_ok = 1'b0;
        endcase
    end

    logic [COST_W-1:0] g_new;
    logic [LEN_W-1:0]  sat_len;
    logic              in_range;
    assign g_new   = best_cost_reg + 1'b1;
    assign sat_len = (32'(best_cost_reg) > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(best_cost_reg);
    assign in_range = (32'(in_sx) < GRID_SIZE) && (32'(in_sy) < GRID_SIZE) &&
                      (32'(in_gx) < GRID_SIZE) && (32'(in_gy) < GRID_SIZE);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        state_next     = state_reg;
        boot_next      = boot_reg;
        clr_next       = clr_reg;
        start_next     = start_reg;
        goal_next      = goal_reg;
        count_next     = count_reg;
        sc_issue_next  = sc_issue_reg;
        sc_v1_next     = 1'b0;
        sc_i1_next     = sc_i1_reg;
        sc_v2_next     = 1'b0;
        sc_i2_next     = sc_i2_reg;
        sc_c2_next     = sc_c2_reg;
        best_idx_next  = best_idx_reg;
        best_cell_next = best_cell_reg;
        best_cost_next = best_cost_reg;
        best_f_next    = best_f_reg;
        sh_rd_next     = sh_rd_reg;
        sh_v_next      = 1'b0;
        sh_w_next      = sh_w_reg;
        nb_d_next      = nb_d_reg;
        tr_c_next      = tr_c_reg;
        tr_step_next   = tr_step_reg;
        tr_guard_next  = tr_guard_reg;
        res_found_next = res_found_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        res_len_next   = res_len_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        wall_we    = 1'b0;
        wall_waddr = {COORD_W'(in_cy), COORD_W'(in_cx)};
        wall_wdata = in_blk;
        st_we      = 1'b0;
        cost_we    = 1'b0;
        par_we     = 1'b0;
        cell_waddr = start_reg;
        st_wdata   = ST_OPEN;
        cost_wdata = '0;
        par_wdata  = DIR_XM;
        cell_raddr = {nb_y, nb_x};
        open_we    = 1'b0;
        open_waddr = '0;
        open_wdata = start_reg;
        open_raddr = sc_issue_reg[OADDR_W-1:0];

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == REQ_CELL) begin
                        wall_we = (32'(in_cx) < GRID_SIZE) && (32'(in_cy) < GRID_SIZE);
                    end else begin
                        res_found_next = 1'b0;
                        res_x_next     = in_sx;
                        res_y_next     = in_sy;
                        res_len_next   = '0;
                        start_next     = {COORD_W'(in_sy), COORD_W'(in_sx)};
                        goal_next      = {COORD_W'(in_gy), COORD_W'(in_gx)};
                        clr_next       = '0;
                        boot_next      = 1'b0;
                        if (in_sx == in_gx && in_sy == in_gy) begin
                            res_found_next = 1'b1;
                            state_next     = S_DONE;
                        end else if (!in_range) begin
                            state_next = S_DONE;
                        end else begin
                            state_next = S_CLR;
                        end
                    end
                end
            end
            S_CLR: begin
                // status sweep, and wall sweep after reset
                st_we      = 1'b1;
                st_wdata   = ST_NEW;
                cell_waddr = clr_reg;
                wall_we    = boot_reg;
                wall_waddr = clr_reg;
                wall_wdata = 1'b0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(ADDR_D - 1)) begin
                    state_next = boot_reg ? S_IDLE : S_INIT;
                    boot_next  = 1'b0;
                end
            end
            S_INIT: begin
                st_we         = 1'b1;
                cost_we       = 1'b1;
                par_we        = 1'b1;
                open_we       = 1'b1;
                count_next    = IDX_W'(1);
                sc_issue_next = '0;
                state_next    = S_SCAN;
            end
            S_SCAN: begin
                // stage 1: open list read, stage 2: cost read, stage 3: compare
                if (sc_issue_reg < count_reg) begin
                    sc_v1_next    = 1'b1;
                    sc_i1_next    = sc_issue_reg;
                    sc_issue_next = sc_issue_reg + 1'b1;
                end
                cell_raddr = open_rdata;
                if (sc_v1_reg) begin
                    sc_v2_next = 1'b1;
                    sc_i2_next = sc_i1_reg;
                    sc_c2_next = open_rdata;
                end
                if (sc_v2_reg) begin
                    if (sc_i2_reg == '0 || sc_f < best_f_reg) begin
                        best_idx_next  = sc_i2_reg;
                        best_cell_next = sc_c2_reg;
                        best_cost_next = cost_rdata;
                        best_f_next    = sc_f;
                    end
                end
                if (sc_issue_reg >= count_reg && !sc_v1_reg && !sc_v2_reg) begin
                    sh_rd_next = best_idx_reg + 1'b1;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT: begin
                // close the gap left by the chosen entry, keeping insertion order
                open_raddr = sh_rd_reg[OADDR_W-1:0];
                if (sh_rd_reg < count_reg) begin
                    sh_v_next  = 1'b1;
                    sh_w_next  = OADDR_W'(sh_rd_reg - 1'b1);
                    sh_rd_next = sh_rd_reg + 1'b1;
                end
                open_we    = sh_v_reg;
                open_waddr = sh_w_reg;
                open_wdata = open_rdata;
                if (sh_rd_reg >= count_reg && !sh_v_reg) begin
                    count_next = count_reg - 1'b1;
                    state_next = S_CLOSE;
                end
            end
            S_CLOSE: begin
                st_we      = 1'b1;
                st_wdata   = ST_CLOSED;
                cell_waddr = best_cell_reg;
                if (best_cell_reg == goal_reg) begin
                    tr_c_next     = goal_reg;
                    tr_step_next  = goal_reg;
                    tr_guard_next = '0;
                    state_next    = S_TRRD;
                end else begin
                    nb_d_next  = DIR_XM;
                    state_next = S_NBRD;
                end
            end
            S_NBRD: begin
                if (nb_ok) begin
                    state_next = S_NBEV;
                end else if (nb_d_reg == DIR_YM) begin
                    state_next = (count_reg == '0) ? S_DONE : S_SCAN;
                    sc_issue_next = '0;
                end else begin
                    nb_d_next = nb_d_reg + 1'b1;
                end
            end
            S_NBEV: begin
                cell_waddr = {nb_y, nb_x};
                cost_wdata = g_new;
                par_wdata  = nb_d_reg;
                st_wdata   = ST_OPEN;
                open_waddr = count_reg[OADDR_W-1:0];
                open_wdata = {nb_y, nb_x};
                if (!wall_rdata && st_rdata != ST_CLOSED) begin
                    if (st_rdata == ST_NEW) begin
                        st_we   = 1'b1;
                        cost_we = 1'b1;
                        par_we  = 1'b1;
                        if (32'(count_reg) < CELLS) begin
                            open_we    = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end else if (g_new < cost_rdata) begin
                        cost_we = 1'b1;
                        par_we  = 1'b1;
                    end
                end
                if (nb_d_reg == DIR_YM) begin
                    state_next    = (count_next == '0) ? S_DONE : S_SCAN;
                    sc_issue_next = '0;
                end else begin
                    nb_d_next  = nb_d_reg + 1'b1;
                    state_next = S_NBRD;
                end
            end
            S_TRRD: begin
                cell_raddr = tr_c_reg;
                if (tr_c_reg == start_reg || 32'(tr_guard_reg) >= CELLS) begin
                    res_found_next = 1'b1;
                    res_x_next     = COORD_IN_W'(tr_step_reg[COORD_W-1:0]);
                    res_y_next     = COORD_IN_W'(tr_step_reg[ADDR_W-1:COORD_W]);
                    res_len_next   = sat_len;
                    state_next     = S_DONE;
                end else begin
                    state_next = S_TREV;
                end
            end
            S_TREV: begin
                tr_step_next = tr_c_reg;
                if (pr_ok) begin
                    tr_c_next     = {pr_y, pr_x};
                    tr_guard_next = tr_guard_reg + 1'b1;
                    state_next    = S_TRRD;
                end else begin
                    res_found_next = 1'b1;
                    res_x_next     = COORD_IN_W'(tr_x);
                    res_y_next     = COORD_IN_W'(tr_y);
                    res_len_next   = sat_len;
                    state_next     = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_DATA_W'({res_len_reg, res_y_reg, res_x_reg,
                                              res_found_reg});
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            boot_reg    <= 1'b1;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            boot_reg    <= boot_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
        start_reg     <= start_next;
        goal_reg      <= goal_next;
        count_reg     <= count_next;
        sc_issue_reg  <= sc_issue_next;
        sc_v1_reg     <= sc_v1_next;
        sc_i1_reg     <= sc_i1_next;
        sc_v2_reg     <= sc_v2_next;
        sc_i2_reg     <= sc_i2_next;
        sc_c2_reg     <= sc_c2_next;
        best_idx_reg  <= best_idx_next;
        best_cell_reg <= best_cell_next;
        best_cost_reg <= best_cost_next;
        best_f_reg    <= best_f_next;
        sh_rd_reg     <= sh_rd_next;
        sh_v_reg      <= sh_v_next;
        sh_w_reg      <= sh_w_next;
        nb_d_reg      <= nb_d_next;
        tr_c_reg      <= tr_c_next;
        tr_step_reg   <= tr_step_next;
        tr_guard_reg  <= tr_guard_next;
        res_found_reg <= res_found_next;
        res_x_reg     <= res_x_next;
        res_y_reg     <= res_y_next;
        res_len_reg   <= res_len_next;
        m_data_reg    <= m_data_next;
    end

endmodule
